// File: hdl/bpg_pkg.sv
// Package for the image header to NAL rewriter: phase, command and slot codes,
// the command record passed from the parser to the emitter, and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package bpg_pkg;

    // Varint limit and queue size
    localparam int VARINT_MAX_BYTES = 5;
    localparam int CMD_DEPTH        = 4;
    localparam int CMD_PTR_W        = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W        = $clog2(CMD_DEPTH + 1);

    // File signature "BPG" 0xFB
    localparam logic [7:0] SIG_BYTES [4] = '{8'h42, 8'h50, 8'h47, 8'hFB};

    // Format byte fields and stream constants
    localparam logic [7:0] FMT_CHROMA_MASK = 8'hE0;
    localparam logic [7:0] FMT_ALPHA_BIT   = 8'h10;
    localparam logic [7:0] FMT_DEPTH_MASK  = 8'h0F;
    localparam logic [7:0] FMT_ALPHA2_BIT  = 8'h04;
    localparam logic [7:0] VARINT_MASK     = 8'h7F;
    localparam logic [7:0] NAL_HDR_TYPE    = 8'(48 << 1);
    localparam logic [7:0] NAL_HDR_LAYER   = 8'h01;
    localparam logic [7:0] EMU_BYTE        = 8'h03;
    localparam logic [7:0] TRAIL_BYTE      = 8'h80;
    localparam logic [7:0] START_LAST      = 8'h01;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_ALPHA     = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Parser phases
    localparam logic [3:0] PH_SIG  = 4'd0;
    localparam logic [3:0] PH_FMT  = 4'd1;
    localparam logic [3:0] PH_WID  = 4'd2;
    localparam logic [3:0] PH_HGT  = 4'd3;
    localparam logic [3:0] PH_DLEN = 4'd4;
    localparam logic [3:0] PH_PLEN = 4'd5;
    localparam logic [3:0] PH_PAY  = 4'd6;
    localparam logic [3:0] PH_PASS = 4'd7;

    // Command kinds
    localparam logic [1:0] CMD_HDR  = 2'd0;
    localparam logic [1:0] CMD_PAY  = 2'd1;
    localparam logic [1:0] CMD_PASS = 2'd2;
    localparam logic [1:0] CMD_ERR  = 2'd3;

    // Emitter slots
    localparam logic [4:0] SL_SC0    = 5'd0;
    localparam logic [4:0] SL_SC1    = 5'd1;
    localparam logic [4:0] SL_SC2    = 5'd2;
    localparam logic [4:0] SL_SC3    = 5'd3;
    localparam logic [4:0] SL_NAL0   = 5'd4;
    localparam logic [4:0] SL_NAL1   = 5'd5;
    localparam logic [4:0] SL_CHROMA = 5'd6;
    localparam logic [4:0] SL_W3     = 5'd7;
    localparam logic [4:0] SL_W2     = 5'd8;
    localparam logic [4:0] SL_W1     = 5'd9;
    localparam logic [4:0] SL_W0     = 5'd10;
    localparam logic [4:0] SL_H3     = 5'd11;
    localparam logic [4:0] SL_H2     = 5'd12;
    localparam logic [4:0] SL_H1     = 5'd13;
    localparam logic [4:0] SL_H0     = 5'd14;
    localparam logic [4:0] SL_DEPTH  = 5'd15;
    localparam logic [4:0] SL_TRAIL  = 5'd16;
    localparam logic [4:0] SL_END0   = 5'd17;
    localparam logic [4:0] SL_END1   = 5'd18;
    localparam logic [4:0] SL_END2   = 5'd19;
    localparam logic [4:0] SL_END3   = 5'd20;
    localparam logic [4:0] SL_PAY    = 5'd21;
    localparam logic [4:0] SL_PASS   = 5'd22;
    localparam logic [4:0] SL_ERR    = 5'd23;

    // One unit of work for the emitter
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  chroma;
        logic [3:0]  depth;
        logic [31:0] width;
        logic [31:0] height;
        logic        finish;
        logic        fin;
        logic [1:0]  status;
    } cmd_t;

    // Parser to queue write side
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_wr_t;

    // Queue to emitter read side
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_rd_t;

endpackage

// File: hdl/bpg_in_if.sv
// Input channel: one file byte per beat with its end-of-file flag.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface bpg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// File: hdl/bpg_out_if.sv
// Output channel: one stream byte per beat with last marker and status.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface bpg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    logic [1:0] status;

    modport source (output valid, output out_byte, output last_out, output status, input ready);
    modport sink (input valid, input out_byte, input last_out, input status, output ready);
endinterface

// File: hdl/bpg_front.sv
// Header parser: checks signature and format, decodes varints, and turns each
// input beat into at most one emitter command. Depends on bpg_pkg, bpg_in_if.
`timescale 1ns / 1ps

module bpg_front
    import bpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bpg_in_if.sink      in_ch,
    input  logic        cmd_full,
    output cmd_wr_t     cmd_wr
);

    logic [3:0]  phase_reg,  phase_next;
    logic [2:0]  idx_reg,    idx_next;
    logic [2:0]  chroma_reg, chroma_next;
    logic [3:0]  depth_reg,  depth_next;
    logic        alpha_reg,  alpha_next;
    logic [31:0] width_reg,  width_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] acc_reg,    acc_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [31:0] left_reg,   left_next;
    logic        hold_reg,   hold_next;

    logic        fire;
    logic [7:0]  b;
    logic        fin;
    logic [31:0] acc_new;
    logic [2:0]  cnt_new;
    logic        vdone;
    logic        do_fail;
    logic [1:0]  fail_st;
    logic        clr;
    logic        push;
    cmd_t        cmd;

    assign in_ch.ready = !cmd_full;
    assign fire        = in_ch.valid && !cmd_full;
    assign b           = in_ch.in_byte;
    assign fin         = in_ch.is_final;

    // Varint step: shift in seven bits, stop on clear high bit or byte limit
    assign acc_new = {acc_reg[24:0], b[6:0] & VARINT_MASK[6:0]};
    assign cnt_new = cnt_reg + 3'd1;
    assign vdone   = !b[7] || (cnt_new >= 3'(VARINT_MAX_BYTES));

    // Classify the beat
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        chroma_next = chroma_reg;
        depth_next  = depth_reg;
        alpha_next  = alpha_reg;
        width_next  = width_reg;
        height_next = height_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        hold_next   = hold_reg;
        do_fail     = 1'b0;
        fail_st     = ST_OK;
        clr         = 1'b0;
        push        = 1'b0;
        cmd         = '0;
        cmd.kind    = CMD_PASS;
        cmd.data    = b;
        cmd.fin     = fin;

        if (hold_reg)
        begin
            // Drop beats until end of file after an error
            clr = fin;
        end
        else
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    if (b != SIG_BYTES[idx_reg[1:0]])
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_BAD_SIG;
                    end
                    else if (idx_reg >= 3'd3)
                    begin
                        if (fin)
                        begin
                            do_fail = 1'b1;
                            fail_st = ST_TRUNCATED;
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                            idx_next   = 3'd0;
                        end
                    end
                    else if (fin)
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_BAD_SIG;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                PH_FMT:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        chroma_next = 3'((b & FMT_CHROMA_MASK) >> 5);
                        alpha_next  = |(b & FMT_ALPHA_BIT);
                        depth_next  = 4'(b & FMT_DEPTH_MASK);
                        idx_next    = 3'd1;
                        if (fin)
                        begin
                            do_fail = 1'b1;
                            fail_st = ST_TRUNCATED;
                        end
                    end
                    else if (alpha_reg || (|(b & FMT_ALPHA2_BIT)))
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_ALPHA;
                    end
                    else if (fin)
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next = PH_WID;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                PH_WID, PH_HGT, PH_DLEN:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                    if (fin)
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_TRUNCATED;
                    end
                    else if (vdone)
                    begin
                        if (phase_reg == PH_WID)
                        begin
                            width_next = acc_new;
                        end
                        if (phase_reg == PH_HGT)
                        begin
                            height_next = acc_new;
                        end
                        phase_next = phase_reg + 4'd1;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                PH_PLEN:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                    if (!vdone)
                    begin
                        if (fin)
                        begin
                            do_fail = 1'b1;
                            fail_st = ST_TRUNCATED;
                        end
                    end
                    else
                    begin
                        left_next = acc_new;
                        acc_next  = '0;
                        cnt_next  = '0;
                        if (fin && (acc_new != '0))
                        begin
                            do_fail = 1'b1;
                            fail_st = ST_TRUNCATED;
                        end
                        else
                        begin
                            // Header burst, with closing start code if no payload
                            push       = 1'b1;
                            cmd.kind   = CMD_HDR;
                            cmd.chroma = chroma_reg;
                            cmd.depth  = depth_reg;
                            cmd.width  = width_reg;
                            cmd.height = height_reg;
                            cmd.finish = (acc_new == '0);
                            if (acc_new == '0)
                            begin
                                clr        = fin;
                                phase_next = PH_PASS;
                            end
                            else
                            begin
                                phase_next = PH_PAY;
                            end
                        end
                    end
                end
                PH_PAY:
                begin
                    if (fin && (left_reg > 32'd1))
                    begin
                        do_fail = 1'b1;
                        fail_st = ST_TRUNCATED;
                    end
                    else
                    begin
                        push       = 1'b1;
                        cmd.kind   = CMD_PAY;
                        cmd.finish = (left_reg <= 32'd1);
                        if (left_reg <= 32'd1)
                        begin
                            left_next  = '0;
                            phase_next = PH_PASS;
                            clr        = fin;
                        end
                        else
                        begin
                            left_next = left_reg - 32'd1;
                        end
                    end
                end
                PH_PASS:
                begin
                    push = 1'b1;
                    clr  = fin;
                end
                default:
                begin
                    clr = 1'b1;
                end
            endcase

            // Error: one result, then hold until end of file
            if (do_fail)
            begin
                push       = 1'b1;
                cmd.kind   = CMD_ERR;
                cmd.status = fail_st;
                hold_next  = 1'b1;
                clr        = fin;
            end
        end

        // Restart after the last byte of a file, or from an unknown phase
        if (clr)
        begin
            phase_next  = PH_SIG;
            idx_next    = '0;
            chroma_next = '0;
            depth_next  = '0;
            alpha_next  = 1'b0;
            width_next  = '0;
            height_next = '0;
            acc_next    = '0;
            cnt_next    = '0;
            left_next   = '0;
            hold_next   = 1'b0;
        end
    end

    assign cmd_wr.push = fire && push;
    assign cmd_wr.cmd  = cmd;

    // Advance parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            idx_reg    <= '0;
            chroma_reg <= '0;
            depth_reg  <= '0;
            alpha_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            hold_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            chroma_reg <= chroma_next;
            depth_reg  <= depth_next;
            alpha_reg  <= alpha_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

// File: hdl/bpg_cmd_fifo.sv
// Short command queue between the parser and the emitter.
// Depends on bpg_pkg.
`timescale 1ns / 1ps

module bpg_cmd_fifo
    import bpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_wr_t wr,
    output logic    full,
    output cmd_rd_t rd,
    input  logic    pop
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign rd.valid = (cnt_reg != '0);
    assign rd.cmd   = mem_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && rd.valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> !full)
        else $error("command pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd.valid)
        else $error("command popped from empty queue");
`endif

endmodule

// File: hdl/bpg_back.sv
// Emitter: expands queued commands into output beats, applies the 00 00 03
// escape and the trailing 0x80, and holds the output register. Depends on bpg_pkg, bpg_out_if.
`timescale 1ns / 1ps

module bpg_back
    import bpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_rd_t    rd,
    output logic       pop,
    bpg_out_if.source  out_ch
);

    logic [4:0] slot_reg;
    logic       started_reg;
    logic       ins_reg;
    logic       pz_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;

    cmd_t       head;
    logic       advance;
    logic [4:0] start_slot;
    logic [4:0] slot;
    logic [4:0] slot_next;
    logic       ins_next;
    logic       pz_next;
    logic       done;
    logic [7:0] beat_byte;
    logic       beat_last;
    logic [1:0] beat_status;
    logic [7:0] esc_byte;

    assign head    = rd.cmd;
    assign advance = rd.valid && (!out_valid_reg || out_ch.ready);
    assign pop     = advance && done;

    // Entry slot for each command kind
    always_comb
    begin
        case (head.kind)
            CMD_HDR:  start_slot = SL_SC0;
            CMD_PAY:  start_slot = SL_PAY;
            CMD_PASS: start_slot = SL_PASS;
            default:  start_slot = SL_ERR;
        endcase
    end

    assign slot = started_reg ? slot_reg : start_slot;

    // Pick the byte to escape
    always_comb
    begin
        case (slot)
            SL_CHROMA: esc_byte = {5'd0, head.chroma};
            SL_W3:     esc_byte = head.width[31:24];
            SL_W2:     esc_byte = head.width[23:16];
            SL_W1:     esc_byte = head.width[15:8];
            SL_W0:     esc_byte = head.width[7:0];
            SL_H3:     esc_byte = head.height[31:24];
            SL_H2:     esc_byte = head.height[23:16];
            SL_H1:     esc_byte = head.height[15:8];
            SL_H0:     esc_byte = head.height[7:0];
            SL_DEPTH:  esc_byte = {4'd0, head.depth};
            default:   esc_byte = head.data;
        endcase
    end

    // Form one beat and the next slot
    always_comb
    begin
        beat_byte   = 8'h00;
        beat_last   = 1'b0;
        beat_status = ST_OK;
        done        = 1'b0;
        slot_next   = slot + 5'd1;
        ins_next    = ins_reg;
        pz_next     = pz_reg;

        case (slot) inside
            SL_SC0:
            begin
                pz_next = 1'b0;
            end
            SL_SC1, SL_SC2:
            begin
                beat_byte = 8'h00;
            end
            SL_SC3, SL_NAL1:
            begin
                beat_byte = NAL_HDR_LAYER;
            end
            SL_NAL0:
            begin
                beat_byte = NAL_HDR_TYPE;
            end
            [SL_CHROMA:SL_DEPTH], SL_PAY:
            begin
                if (ins_reg)
                begin
                    beat_byte = EMU_BYTE;
                    ins_next  = 1'b0;
                    pz_next   = 1'b0;
                end
                else if ((esc_byte == 8'h00) && pz_reg)
                begin
                    // Zero pair: emit the zero now, the 0x03 next
                    beat_byte = 8'h00;
                    ins_next  = 1'b1;
                end
                else
                begin
                    beat_byte = esc_byte;
                    pz_next   = (esc_byte == 8'h00);
                end

                if (!ins_next && ((slot == SL_DEPTH) || (slot == SL_PAY)))
                begin
                    if (head.finish)
                    begin
                        slot_next = pz_next ? SL_TRAIL : SL_END0;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else if (ins_next)
                begin
                    slot_next = slot;
                end
            end
            SL_TRAIL:
            begin
                beat_byte = TRAIL_BYTE;
                pz_next   = 1'b0;
            end
            SL_END0, SL_END1, SL_END2:
            begin
                beat_byte = 8'h00;
            end
            SL_END3:
            begin
                beat_byte = START_LAST;
                beat_last = head.fin;
                pz_next   = 1'b0;
                done      = 1'b1;
            end
            SL_PASS:
            begin
                beat_byte = head.data;
                beat_last = head.fin;
                done      = 1'b1;
            end
            SL_ERR:
            begin
                beat_byte   = 8'h00;
                beat_last   = 1'b1;
                beat_status = head.status;
                pz_next     = 1'b0;
                done        = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= SL_SC0;
            started_reg <= 1'b0;
            ins_reg     <= 1'b0;
            pz_reg      <= 1'b0;
        end
        else if (advance)
        begin
            slot_reg    <= slot_next;
            started_reg <= !done;
            ins_reg     <= done ? 1'b0 : ins_next;
            pz_reg      <= pz_next;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= beat_byte;
            out_last_reg   <= beat_last;
            out_status_reg <= beat_status;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last_out = out_last_reg;
    assign out_ch.status   = out_status_reg;

`ifndef NO_ASSERTIONS
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_last_reg && (out_byte_reg == 8'h00)))
        else $error("error beat must be a final zero byte");
    a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ins_reg |-> (started_reg && (((slot_reg >= SL_CHROMA) && (slot_reg <= SL_DEPTH))
                                     || (slot_reg == SL_PAY))))
        else $error("escape insert pending outside an escaped slot");
    a_trail_pz: assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg && (slot_reg == SL_TRAIL)) |-> pz_reg)
        else $error("trailing 0x80 without a pending zero");
`endif

endmodule

// File: hdl/bpg_header_to_nal_rewriter.sv
// Channel  | Dir | Beat payload                 | Accept
// in_ch    | in  | in_byte[7:0], is_final       | valid && ready
// out_ch   | out | out_byte[7:0], last_out, status[1:0] | valid && ready
//
// One output beat per cycle while out_ch is ready. Payload and pass-through
// bytes sustain one byte per cycle while out_ch is ready; a header burst (up
// to 25 beats), an inserted 0x03 or a closing start code adds emitter beats.
// The four-entry command queue absorbs these bursts; input stalls when it fills.
// Reset is asynchronous and clears all control state; no clearing pass.
// Top level: parser, command queue, emitter. Depends on bpg_pkg, bpg_in_if,
// bpg_out_if, bpg_front, bpg_cmd_fifo, bpg_back.
`timescale 1ns / 1ps

module bpg_header_to_nal_rewriter
    import bpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bpg_in_if.sink     in_ch,
    bpg_out_if.source  out_ch
);

    cmd_wr_t cmd_wr;
    cmd_rd_t cmd_rd;
    logic    cmd_full;
    logic    cmd_pop;

    bpg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cmd_full (cmd_full),
        .cmd_wr   (cmd_wr)
    );

    bpg_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .full  (cmd_full),
        .rd    (cmd_rd),
        .pop   (cmd_pop)
    );

    bpg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (cmd_rd),
        .pop    (cmd_pop),
        .out_ch (out_ch)
    );

endmodule

// File: verif/tb_bpg_header_to_nal_rewriter.sv
// Testbench for bpg_header_to_nal_rewriter: feeds image files byte by byte and checks
// the rewritten NAL stream beat by beat against a built-in parser and escaper.
// Depends on bpg_pkg, bpg_in_if, bpg_out_if and the rewriter RTL.
`timescale 1ns / 1ps

module tb_bpg_header_to_nal_rewriter;
    import bpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_ITEMS    = 135;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } file_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
        logic [1:0] status;
    } nal_beat_t;

    logic clk;
    logic rst_n;

    bpg_in_if  in_ch ();
    bpg_out_if out_ch ();

    bpg_header_to_nal_rewriter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Stimulus and expectation stores
    file_beat_t  byte_feed [$];
    nal_beat_t   nal_expect [$];
    logic [7:0]  file_q [$];
    file_beat_t  next_item;
    nal_beat_t   want_beat;
    nal_beat_t   got_beat;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          items_queued;
    int          items_in;
    int          beats_checked;
    int          err_count;
    int          idle_cycles;
    int          good_files;
    int          broken_files;
    int          noise_files;

    // Parser state of the predictor
    logic [3:0]  parse_phase;
    logic [2:0]  sig_idx;
    logic [2:0]  fmt_chroma;
    logic [3:0]  fmt_depth;
    logic        fmt_alpha;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [31:0] vint_acc;
    logic [2:0]  vint_cnt;
    logic [31:0] pay_left;
    logic        zero_run;
    logic        err_hold;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic restart_parse();
        parse_phase = PH_SIG;
        sig_idx     = '0;
        fmt_chroma  = '0;
        fmt_depth   = '0;
        fmt_alpha   = 1'b0;
        img_width   = '0;
        img_height  = '0;
        vint_acc    = '0;
        vint_cnt    = '0;
        pay_left    = '0;
        zero_run    = 1'b0;
        err_hold    = 1'b0;
    endtask

    task automatic push_nal(input logic [7:0] b, input logic is_last, input logic [1:0] st);
        nal_expect.push_back('{data: b, is_last: is_last, status: st});
    endtask

    task automatic raise_error(input logic [1:0] st, input logic fin);
        push_nal(8'h00, 1'b1, st);
        err_hold = 1'b1;
        if (fin)
            restart_parse();
    endtask

    // Insert the emulation byte after two zeros in a row
    task automatic emit_escaped(input logic [7:0] b);
        if (b == 8'h00 && zero_run)
        begin
            push_nal(8'h00, 1'b0, ST_OK);
            push_nal(EMU_BYTE, 1'b0, ST_OK);
            zero_run = 1'b0;
        end
        else
        begin
            push_nal(b, 1'b0, ST_OK);
            zero_run = (b == 8'h00);
        end
    endtask

    task automatic emit_word(input logic [31:0] w);
        emit_escaped(w[31:24]);
        emit_escaped(w[23:16]);
        emit_escaped(w[15:8]);
        emit_escaped(w[7:0]);
    endtask

    task automatic emit_start_code(input logic fin);
        push_nal(8'h00, 1'b0, ST_OK);
        push_nal(8'h00, 1'b0, ST_OK);
        push_nal(8'h00, 1'b0, ST_OK);
        push_nal(START_LAST, fin, ST_OK);
    endtask

    // Close the header NAL: trailing byte if it ends in zero, then a start code
    task automatic close_nal(input logic fin);
        if (zero_run)
            push_nal(TRAIL_BYTE, 1'b0, ST_OK);
        zero_run = 1'b0;
        emit_start_code(fin);
        if (fin)
            restart_parse();
        else
            parse_phase = PH_PASS;
    endtask

    task automatic predict_rewrite(input logic [7:0] b, input logic fin);
        logic done;
        if (err_hold)
        begin
            if (fin)
                restart_parse();
            return;
        end
        case (parse_phase)
            PH_SIG:
            begin
                if (b != SIG_BYTES[sig_idx[1:0]])
                    raise_error(ST_BAD_SIG, fin);
                else if (sig_idx >= 3)
                begin
                    if (fin)
                        raise_error(ST_TRUNCATED, fin);
                    else
                    begin
                        parse_phase = PH_FMT;
                        sig_idx     = '0;
                    end
                end
                else if (fin)
                    raise_error(ST_BAD_SIG, fin);
                else
                    sig_idx = sig_idx + 3'd1;
            end
            PH_FMT:
            begin
                if (sig_idx == 0)
                begin
                    fmt_chroma = b[7:5];
                    fmt_alpha  = |(b & FMT_ALPHA_BIT);
                    fmt_depth  = b[3:0];
                    sig_idx    = 3'd1;
                    if (fin)
                        raise_error(ST_TRUNCATED, fin);
                end
                else if (fmt_alpha || |(b & FMT_ALPHA2_BIT))
                    raise_error(ST_ALPHA, fin);
                else if (fin)
                    raise_error(ST_TRUNCATED, fin);
                else
                begin
                    parse_phase = PH_WID;
                    vint_acc    = '0;
                    vint_cnt    = '0;
                end
            end
            PH_WID, PH_HGT, PH_DLEN, PH_PLEN:
            begin
                vint_acc = (vint_acc << 7) | {25'd0, b[6:0]};
                vint_cnt = vint_cnt + 3'd1;
                done     = !b[7] || (vint_cnt >= VARINT_MAX_BYTES);
                if (!done)
                begin
                    if (fin)
                        raise_error(ST_TRUNCATED, fin);
                end
                else if (parse_phase != PH_PLEN)
                begin
                    if (fin)
                        raise_error(ST_TRUNCATED, fin);
                    else
                    begin
                        if (parse_phase == PH_WID)
                            img_width = vint_acc;
                        else if (parse_phase == PH_HGT)
                            img_height = vint_acc;
                        parse_phase = parse_phase + 4'd1;
                        vint_acc    = '0;
                        vint_cnt    = '0;
                    end
                end
                else
                begin
                    pay_left = vint_acc;
                    vint_acc = '0;
                    vint_cnt = '0;
                    if (fin && pay_left != 0)
                        raise_error(ST_TRUNCATED, fin);
                    else
                    begin
                        // Header burst: start code, NAL header, escaped fields
                        emit_start_code(1'b0);
                        push_nal(NAL_HDR_TYPE, 1'b0, ST_OK);
                        push_nal(NAL_HDR_LAYER, 1'b0, ST_OK);
                        zero_run = 1'b0;
                        emit_escaped({5'd0, fmt_chroma});
                        emit_word(img_width);
                        emit_word(img_height);
                        emit_escaped({4'd0, fmt_depth});
                        if (pay_left == 0)
                            close_nal(fin);
                        else
                            parse_phase = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                if (fin && pay_left > 1)
                    raise_error(ST_TRUNCATED, fin);
                else
                begin
                    emit_escaped(b);
                    if (pay_left <= 1)
                    begin
                        pay_left = '0;
                        close_nal(fin);
                    end
                    else
                        pay_left = pay_left - 32'd1;
                end
            end
            PH_PASS:
            begin
                push_nal(b, fin, ST_OK);
                if (fin)
                    restart_parse();
            end
            default:
                restart_parse();
        endcase
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    task automatic queue_file();
        int i;
        for (i = 0; i < file_q.size(); i++)
            byte_feed.push_back('{data: file_q[i], fin: (i == file_q.size() - 1)});
        items_queued += file_q.size();
        file_q.delete();
    endtask

    task automatic put_varint(input logic [34:0] v, input int nbytes, input logic overlong);
        logic [7:0] grp;
        int i;
        for (i = nbytes - 1; i >= 0; i--)
        begin
            grp = {1'b0, 7'(v >> (7 * i))};
            if (i > 0 || overlong)
                grp[7] = 1'b1;
            file_q.push_back(grp);
        end
    endtask

    // Encode with the fewest groups, sometimes padded, overlong or wrapping past 32 bits
    task automatic put_length(input logic [31:0] v, input logic allow_wrap);
        int n;
        logic [34:0] wide;
        n = 1;
        while (n < VARINT_MAX_BYTES && (v >> (7 * n)) != 0)
            n++;
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(n, VARINT_MAX_BYTES);
        wide = {3'b000, v};
        if (allow_wrap && n == VARINT_MAX_BYTES && $urandom_range(0, 1) == 1)
            wide[34:32] = 3'($urandom_range(1, 7));
        put_varint(wide, n, allow_wrap && n == VARINT_MAX_BYTES && $urandom_range(0, 3) == 0);
    endtask

    function automatic logic [31:0] pick_dimension();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 127));
            2: return 32'($urandom_range(128, 20000));
            3: return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // Zero-heavy bytes so the escape rule fires often
    function automatic logic [7:0] pick_data_byte();
        if ($urandom_range(0, 9) < 4)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_good_file();
        int i;
        int plen;
        int tail;
        logic [7:0] fmt2;
        for (i = 0; i < 4; i++)
            file_q.push_back(SIG_BYTES[i]);
        file_q.push_back({3'($urandom), 1'b0, 4'($urandom)});
        fmt2 = 8'($urandom) & ~FMT_ALPHA2_BIT;
        file_q.push_back(fmt2);
        put_length(pick_dimension(), 1'b1);
        put_length(pick_dimension(), 1'b1);
        put_length(pick_dimension(), 1'b1);
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        put_length(32'(plen), 1'b0);
        for (i = 0; i < plen; i++)
            file_q.push_back(pick_data_byte());
        tail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        for (i = 0; i < tail; i++)
            file_q.push_back(pick_data_byte());
    endtask

    // Mostly well-formed files, mixed at random with broken ones and plain noise
    task automatic queue_random_files(input int target);
        int start_cnt;
        int pick;
        int k;
        start_cnt = items_queued;
        while (items_queued - start_cnt < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                build_good_file();
                good_files++;
            end
            else if (pick < 85)
            begin
                build_good_file();
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        k = $urandom_range(1, file_q.size() - 1);
                        while (file_q.size() > k)
                            void'(file_q.pop_back());
                    end
                    2: file_q[$urandom_range(0, 3)] = 8'($urandom);
                    default:
                    begin
                        if ($urandom_range(0, 1) == 1)
                            file_q[4] = file_q[4] | FMT_ALPHA_BIT;
                        else
                            file_q[5] = file_q[5] | FMT_ALPHA2_BIT;
                    end
                endcase
                broken_files++;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                    file_q.push_back(8'($urandom));
                noise_files++;
            end
            queue_file();
        end
    endtask

    task automatic wait_drain();
        while (byte_feed.size() != 0 || in_ch.valid || nal_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input nal_beat_t want, input nal_beat_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] %s: exp byte=%02h last=%0b status=%0d, got byte=%02h last=%0b status=%0d",
                     $time, what, want.data, want.is_last, want.status,
                     got.data, got.is_last, got.status);
    endtask

    // ------------------------------------------------------------------
    // Driver: predict on each accepted beat, then present the next one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.in_byte  <= 8'h00;
            in_ch.is_final <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_rewrite(in_ch.in_byte, in_ch.is_final);
                items_in++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = byte_feed.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.in_byte  <= next_item.data;
                    in_ch.is_final <= next_item.fin;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted output beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got_beat = '{data: out_ch.out_byte, is_last: out_ch.last_out,
                             status: out_ch.status};
                beats_checked++;
                if (nal_expect.size() == 0)
                    note_mismatch("unexpected beat", '0, got_beat);
                else
                begin
                    want_beat = nal_expect.pop_front();
                    if (got_beat.data !== want_beat.data
                        || got_beat.is_last !== want_beat.is_last
                        || got_beat.status !== want_beat.status)
                        note_mismatch("beat mismatch", want_beat, got_beat);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: stop when work is outstanding but nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (byte_feed.size() != 0 || in_ch.valid || nal_expect.size() != 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, nal_expect.size());
                $display("** bpg_header_to_nal_rewriter: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.is_final = 1'b0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 11;
        recv_idle_pct  = 55;
        items_queued   = 0;
        items_in       = 0;
        beats_checked  = 0;
        err_count      = 0;
        idle_cycles    = 0;
        good_files     = 0;
        broken_files   = 0;
        noise_files    = 0;
        restart_parse();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wrong first byte on a one-byte file
        file_q = {8'h00};
        queue_file();
        // File ends inside the signature
        file_q = {8'h42, 8'h50};
        queue_file();
        // File ends right after the signature
        file_q = {8'h42, 8'h50, 8'h47, 8'hFB};
        queue_file();
        // Alpha flag in the first format byte, then a byte that is dropped
        file_q = {8'h42, 8'h50, 8'h47, 8'hFB, 8'h10, 8'h00, 8'hFF};
        queue_file();
        // Zero-size image, empty payload, final on the length byte: escapes and trailer
        file_q = {8'h42, 8'h50, 8'h47, 8'hFB, 8'hE0, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_file();

        queue_random_files(PHASE_ITEMS);
        wait_drain();

        // Swap the stall mix once everything has drained
        send_idle_pct = 55;
        recv_idle_pct = 11;
        queue_random_files(PHASE_ITEMS);
        wait_drain();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_files(PHASE_ITEMS);
        wait_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (nal_expect.size() != 0)
        begin
            err_count += nal_expect.size();
            $display("%0d expected beats never arrived", nal_expect.size());
        end

        $display("Sent %0d bytes in %0d well-formed, %0d damaged and %0d noise files; %0d beats checked.",
                 items_in, good_files, broken_files, noise_files, beats_checked);
        $display("Stall mixes: light sender/heavy receiver, the reverse, then none; %0d mismatches.",
                 err_count);
        if (err_count == 0)
            $display("** bpg_header_to_nal_rewriter: PASSED **");
        else
            $display("** bpg_header_to_nal_rewriter: FAILED **");
        $finish;
    end

endmodule
